// ===== rtl/lpmr_pkg.sv =====
// Shared types and codes for the longest-prefix-match router.
// Used by lpmr_cell and longest_prefix_match_router; no dependencies.
package lpmr_pkg;

    // Transaction token that walks the cell chain. For an add it carries the
    // route; for a lookup the route fields carry the best match so far.
    typedef struct packed {
        logic        valid;
        logic        is_add;
        logic        done;     // add: stored in a cell; lookup: a route matched
        logic [31:0] addr;     // add: prefix; lookup: destination
        logic [5:0]  len;      // add: saturated length; lookup: best length
        logic [31:0] mask;     // add: prefix mask built from the length
        logic        has_gw;
        logic [31:0] gw;
        logic [3:0]  port;
        logic [7:0]  ttl;
    } lpmr_token_t;

    localparam logic OP_ADD    = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [2:0] ST_ADDED       = 3'd0;
    localparam logic [2:0] ST_TABLE_FULL  = 3'd1;
    localparam logic [2:0] ST_FORWARDED   = 3'd2;
    localparam logic [2:0] ST_NO_ROUTE    = 3'd3;
    localparam logic [2:0] ST_TTL_EXPIRED = 3'd4;

    localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

endpackage

// ===== rtl/lpmr_cell.sv =====
// One route cell of the router chain: holds a single route and the token stage.
// Depends on lpmr_pkg.
module lpmr_cell
    import lpmr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        advance,
    input  lpmr_token_t tok_in,
    output lpmr_token_t tok_out
);

    logic        occupied_reg;
    logic        tok_valid_reg;
    lpmr_token_t tok_reg;
    lpmr_token_t tok_next;
    logic [31:0] prefix_reg;
    logic [31:0] mask_reg;
    logic [5:0]  len_reg;
    logic        has_gw_reg;
    logic [31:0] gw_reg;
    logic [3:0]  port_reg;
    logic        take_add;
    logic        hit;

    // Claim this cell for the first add that finds it empty.
    assign take_add = tok_in.valid && tok_in.is_add && !tok_in.done && !occupied_reg;

    // Replace the best match only on a strictly longer prefix: earlier routes win ties.
    assign hit = tok_in.valid && !tok_in.is_add && occupied_reg
                 && (((tok_in.addr ^ prefix_reg) & mask_reg) == 32'd0)
                 && (!tok_in.done || (len_reg > tok_in.len));

    always_comb begin
        tok_next = tok_in;
        if (take_add) begin
            tok_next.done = 1'b1;
        end
        if (hit) begin
            tok_next.done   = 1'b1;
            tok_next.len    = len_reg;
            tok_next.has_gw = has_gw_reg;
            tok_next.gw     = gw_reg;
            tok_next.port   = port_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occupied_reg  <= 1'b0;
            tok_valid_reg <= 1'b0;
        end else if (advance) begin
            tok_valid_reg <= tok_in.valid;
            if (take_add) begin
                occupied_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            tok_reg <= tok_next;
            if (take_add) begin
                prefix_reg <= tok_in.addr;
                mask_reg   <= tok_in.mask;
                len_reg    <= tok_in.len;
                has_gw_reg <= tok_in.has_gw;
                gw_reg     <= tok_in.gw;
                port_reg   <= tok_in.port;
            end
        end
    end

    always_comb begin
        tok_out       = tok_reg;
        tok_out.valid = tok_valid_reg;
    end

endmodule

// ===== rtl/longest_prefix_match_router.sv =====
// Top level of the IPv4 longest-prefix-match router.
// Depends on lpmr_pkg and lpmr_cell.
//
// Route table as a systolic chain of MAX_ROUTES cells, one route per cell.
// Every transaction (add or lookup) enters cell 0 and moves one cell per
// cycle. An add settles in the first empty cell it passes; a lookup compares
// against each occupied cell and carries the longest match seen so far, so
// the earliest added route wins a tie. Because transactions never overtake
// each other, a lookup sees exactly the routes added before it. The chain
// accepts one transaction per cycle while no result is stalled; each result
// passes the register of every cell and then the result register before it
// shows on m_tvalid, and the whole chain holds while a result waits on
// m_tready. An add that passes every cell without finding room answers
// table full.
module longest_prefix_match_router
    import lpmr_pkg::*;
#(
    parameter int MAX_ROUTES = 64,
    parameter int NUM_PORTS  = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // prefix[31:0], prefix_len[37:32], has_gateway[38],
    // gateway_address[70:39], out_port[74:71], dst_address[106:75],
    // hop_limit[114:107], zero pad[119:115]
    input  logic [119:0] s_tdata,
    // op[0]: 0 add route, 1 route datagram
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], forward_port[6:3], hop_address[38:7],
    // new_hop_limit[46:39], zero pad[47]
    output logic [47:0]  m_tdata
);

    localparam logic [8:0] PORT_LIMIT = 9'(NUM_PORTS);
    localparam logic [3:0] PORT_MAX   = 4'(NUM_PORTS - 1);

    lpmr_token_t chain [MAX_ROUTES+1];
    lpmr_token_t tail;
    logic        advance;
    logic [5:0]  in_len;
    logic [3:0]  in_port;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [47:0] m_tdata_reg;
    logic [47:0] m_tdata_next;
    logic [2:0]  res_status;
    logic [3:0]  res_port;
    logic [31:0] res_hop;
    logic [7:0]  res_ttl;

    // Advance the whole chain unless a result is stalled at the output.
    assign advance  = !m_tvalid_reg || m_tready;
    assign s_tready = advance;

    // Saturate length and port, and build the prefix mask once at entry.
    always_comb begin
        in_len = s_tdata[37:32];
        if (in_len > MAX_PREFIX_LEN) begin
            in_len = MAX_PREFIX_LEN;
        end
        in_port = s_tdata[74:71];
        if ({5'd0, in_port} >= PORT_LIMIT) begin
            in_port = PORT_MAX;
        end
    end

    always_comb begin
        chain[0].valid  = s_tvalid && advance;
        chain[0].is_add = (s_tuser == OP_ADD);
        chain[0].done   = 1'b0;
        chain[0].addr   = (s_tuser == OP_ADD) ? s_tdata[31:0] : s_tdata[106:75];
        chain[0].len    = in_len;
        chain[0].mask   = ~(32'hFFFF_FFFF >> in_len);
        chain[0].has_gw = s_tdata[38];
        chain[0].gw     = s_tdata[70:39];
        chain[0].port   = in_port;
        chain[0].ttl    = s_tdata[114:107];
    end

    for (genvar i = 0; i < MAX_ROUTES; i++) begin : g_cell
        lpmr_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_in  (chain[i]),
            .tok_out (chain[i+1])
        );
    end

    assign tail = chain[MAX_ROUTES];

    // Turn the token leaving the last cell into a result.
    always_comb begin
        res_status = ST_ADDED;
        res_port   = 4'd0;
        res_hop    = 32'd0;
        res_ttl    = 8'd0;
        if (tail.is_add) begin
            res_status = tail.done ? ST_ADDED : ST_TABLE_FULL;
        end else if (!tail.done) begin
            res_status = ST_NO_ROUTE;
        end else if (tail.ttl <= 8'd1) begin
            res_status = ST_TTL_EXPIRED;
        end else begin
            res_status = ST_FORWARDED;
            res_port   = tail.port;
            res_hop    = tail.has_gw ? tail.gw : tail.addr;
            res_ttl    = tail.ttl - 8'd1;
        end
    end

    assign m_tvalid_next = advance ? tail.valid : m_tvalid_reg;
    assign m_tdata_next  = advance ? {1'b0, res_ttl, res_hop, res_port, res_status}
                                   : m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== bench/longest_prefix_match_router_tb.sv =====
// Self-checking bench for the longest-prefix-match router: directed and random
// add/lookup transactions against a route table predictor in a scoreboard class.
// Depends on lpmr_pkg and the RTL top level longest_prefix_match_router.
module longest_prefix_match_router_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lpmr_pkg::*;

    localparam int ROUTE_SLOTS   = 64;
    localparam int PORT_COUNT    = 16;
    localparam int RANDOM_ITEMS  = 700;
    // Registers a transaction passes: one per cell plus the result register.
    localparam int CHAIN_LATENCY = ROUTE_SLOTS + 1;
    // Cycles without any transaction on either side before giving up.
    localparam int IDLE_LIMIT    = 2000;

    // One request as it enters the block; in random requests the fields that
    // the op ignores still carry random values.
    typedef struct {
        bit          op;
        bit [31:0]   prefix;
        bit [5:0]    plen;
        bit          has_gw;
        bit [31:0]   gw;
        bit [3:0]    port;
        bit [31:0]   dst;
        bit [7:0]    ttl;
    } route_req_t;

    typedef struct {
        bit [2:0]    status;
        bit [3:0]    port;
        bit [31:0]   hop_addr;
        bit [7:0]    ttl;
    } route_verdict_t;

    // Shadow of the route table plus the verdicts still owed by the block.
    class route_table_model;
        bit [31:0]      prefix_tbl[ROUTE_SLOTS];
        bit [5:0]       len_tbl[ROUTE_SLOTS];
        bit             gw_valid_tbl[ROUTE_SLOTS];
        bit [31:0]      gw_tbl[ROUTE_SLOTS];
        bit [3:0]       port_tbl[ROUTE_SLOTS];
        int             route_count;
        int             failures;
        route_verdict_t pending_verdicts[$];

        function route_verdict_t predict_verdict(route_req_t r);
            route_verdict_t v;
            bit             found;
            int             best;
            bit [31:0]      mask;
            v = '{default: '0};
            found = 1'b0;
            best = 0;
            if (r.op == OP_ADD) begin
                if (route_count >= ROUTE_SLOTS) begin
                    v.status = ST_TABLE_FULL;
                end else begin
                    prefix_tbl[route_count]   = r.prefix;
                    len_tbl[route_count]      = (r.plen > MAX_PREFIX_LEN) ? MAX_PREFIX_LEN
                                                                          : r.plen;
                    gw_valid_tbl[route_count] = r.has_gw;
                    gw_tbl[route_count]       = r.gw;
                    port_tbl[route_count]     = (int'(r.port) >= PORT_COUNT)
                                                ? 4'(PORT_COUNT - 1) : r.port;
                    route_count++;
                    v.status = ST_ADDED;
                end
            end else begin
                // Strictly longer wins, so the earliest route keeps a tie.
                for (int i = 0; i < route_count; i++) begin
                    mask = ~(32'hFFFF_FFFF >> len_tbl[i]);
                    if (((r.dst ^ prefix_tbl[i]) & mask) == 32'h0) begin
                        if (!found || len_tbl[i] > len_tbl[best]) begin
                            best = i;
                            found = 1'b1;
                        end
                    end
                end
                if (!found) begin
                    v.status = ST_NO_ROUTE;
                end else if (r.ttl <= 8'd1) begin
                    v.status = ST_TTL_EXPIRED;
                end else begin
                    v.status   = ST_FORWARDED;
                    v.port     = port_tbl[best];
                    v.hop_addr = gw_valid_tbl[best] ? gw_tbl[best] : r.dst;
                    v.ttl      = r.ttl - 8'd1;
                end
            end
            return v;
        endfunction

        function void accept_item(route_req_t r);
            pending_verdicts.push_back(predict_verdict(r));
        endfunction

        function void compare_field(string name, bit [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
                failures++;
            end
        endfunction

        function void check_verdict(logic [47:0] data);
            route_verdict_t want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h", $time, data);
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            compare_field("status", 32'(want.status), 32'(data[2:0]));
            compare_field("forward_port", 32'(want.port), 32'(data[6:3]));
            compare_field("hop_address", want.hop_addr, data[38:7]);
            compare_field("new_hop_limit", 32'(want.ttl), 32'(data[46:39]));
        endfunction
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // prefix[31:0], prefix_len[37:32], has_gateway[38],
    // gateway_address[70:39], out_port[74:71], dst_address[106:75],
    // hop_limit[114:107], zero pad[119:115]
    logic [119:0] s_tdata;
    // op[0]: 0 add route, 1 route datagram
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    // status[2:0], forward_port[6:3], hop_address[38:7],
    // new_hop_limit[46:39], zero pad[47]
    logic [47:0]  m_tdata;

    route_table_model route_table;
    int               idle_cycles = 0;

    longest_prefix_match_router #(
        .MAX_ROUTES (ROUTE_SLOTS),
        .NUM_PORTS  (PORT_COUNT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic route_req_t make_add(bit [31:0] prefix, bit [5:0] plen, bit has_gw,
                                            bit [31:0] gw, bit [3:0] port);
        route_req_t r;
        r = '{default: '0};
        r.op     = OP_ADD;
        r.prefix = prefix;
        r.plen   = plen;
        r.has_gw = has_gw;
        r.gw     = gw;
        r.port   = port;
        return r;
    endfunction

    function automatic route_req_t lookup(bit [31:0] dst, bit [7:0] ttl);
        route_req_t r;
        r = '{default: '0};
        r.op  = OP_LOOKUP;
        r.dst = dst;
        r.ttl = ttl;
        return r;
    endfunction

    // Random request shaped to hit stored routes: adds often nest under or tie
    // with existing prefixes, and most lookups land inside a stored prefix.
    function automatic route_req_t random_request();
        route_req_t r;
        int         add_pct;
        int         k;
        int         pick;
        bit [31:0]  mask;
        r.prefix = $urandom;
        r.has_gw = 1'($urandom_range(0, 1));
        r.gw     = $urandom;
        r.port   = 4'($urandom_range(0, 15));
        r.dst    = $urandom;
        r.ttl    = 8'($urandom_range(0, 255));
        // Keep some adds after the table fills so table full shows up repeatedly.
        add_pct = (route_table.route_count < ROUTE_SLOTS) ? 15 : 6;
        r.op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_LOOKUP;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            r.plen = 6'(8 * (1 + $urandom_range(0, 3)));
        else if (pick < 9)
            r.plen = 6'($urandom_range(0, 32));
        else
            r.plen = 6'($urandom_range(33, 63));
        if (route_table.route_count > 0) begin
            k = $urandom_range(0, route_table.route_count - 1);
            mask = ~(32'hFFFF_FFFF >> route_table.len_tbl[k]);
            if (r.op == OP_ADD && $urandom_range(0, 2) == 0)
                r.prefix = (route_table.prefix_tbl[k] & mask) | ($urandom & ~mask);
            if (r.op == OP_LOOKUP && $urandom_range(0, 3) != 0)
                r.dst = (route_table.prefix_tbl[k] & mask) | ($urandom & ~mask);
        end
        // Lean on the TTL edges: expired, just alive, and the maximum.
        pick = $urandom_range(0, 9);
        if (pick < 4)
            r.ttl = 8'(pick == 3 ? 255 : pick);
        return r;
    endfunction

    // Present one request after an idle gap and hold it until accepted.
    // s_tready is sampled at the falling edge, where it already shows what
    // the next rising edge will see.
    task automatic send_request(route_req_t r, int gap);
        bit taken;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.op;
        s_tdata  <= {5'b0, r.ttl, r.dst, r.port, r.gw, r.has_gw, r.plen, r.prefix};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        route_table.accept_item(r);
    endtask

    initial begin : stimulus
        route_req_t directed[$];
        int         gap_max;
        route_table = new();
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_ADD;
        repeat (7) @(posedge aclk);
        aresetn  <= 1'b1;

        // Empty table: no route whatever the TTL.
        directed.push_back(lookup(32'h0000_0000, 8'd255));
        directed.push_back(lookup(32'hFFFF_FFFF, 8'd0));
        // Two identical /8 routes: the first one added must win the tie.
        directed.push_back(make_add(32'h0A00_0000, 6'd8, 1'b1, 32'h0A00_00FE, 4'd1));
        directed.push_back(make_add(32'h0A00_0000, 6'd8, 1'b1, 32'h0A00_00FD, 4'd2));
        // Direct /16 route with a stray gateway that must be ignored.
        directed.push_back(make_add(32'h0A01_0000, 6'd16, 1'b0, 32'hDEAD_BEEF, 4'd15));
        // Overlong prefix length saturates to a host route.
        directed.push_back(make_add(32'hC0A8_0101, 6'd63, 1'b1, 32'hFFFF_FFFF, 4'd7));
        // Default route matches everything.
        directed.push_back(make_add(32'hFFFF_FFFF, 6'd0, 1'b1, 32'h0102_0304, 4'd3));
        directed.push_back(make_add(32'hFFFF_FFFF, 6'd32, 1'b1, 32'h0000_0000, 4'd0));
        directed.push_back(make_add(32'h8000_0000, 6'd33, 1'b0, 32'h0000_0000, 4'd8));
        directed.push_back(lookup(32'h0A02_0304, 8'd64));
        directed.push_back(lookup(32'h0A01_FFFF, 8'd2));
        directed.push_back(lookup(32'hC0A8_0101, 8'd255));
        directed.push_back(lookup(32'hC0A8_0100, 8'd9));
        directed.push_back(lookup(32'h0A01_0000, 8'd1));
        directed.push_back(lookup(32'h0A01_0000, 8'd0));
        directed.push_back(lookup(32'hFFFF_FFFF, 8'd128));
        directed.push_back(lookup(32'hFFFF_FFFE, 8'd3));
        directed.push_back(lookup(32'h8000_0000, 8'd2));
        directed.push_back(lookup(32'h0000_0000, 8'd2));
        foreach (directed[i])
            send_request(directed[i], $urandom_range(0, 3));

        // Each burst of requests runs either with no gaps or with random gaps, picked at random.
        gap_max = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0)
                gap_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
            if (n == RANDOM_ITEMS / 2) begin
                // Hold off until the chain has answered everything in flight.
                s_tvalid <= 1'b0;
                do @(posedge aclk); while (route_table.pending_verdicts.size() != 0);
            end
            send_request(random_request(), $urandom_range(0, gap_max));
        end
        s_tvalid <= 1'b0;

        // Drain, then give the chain time to show any stray result.
        do @(posedge aclk); while (route_table.pending_verdicts.size() != 0);
        repeat (CHAIN_LATENCY + 8) @(posedge aclk);
        if (route_table.failures == 0 && route_table.pending_verdicts.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Result side: stall a random number of cycles before each result, with
    // stretches where m_tready stays high throughout.
    initial begin : result_sink
        int          stall_max;
        int          results_seen;
        bit          got;
        logic [47:0] data;
        stall_max = 0;
        results_seen = 0;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (results_seen % 50 == 0)
                stall_max = ($urandom_range(0, 2) == 0) ? 0 : 17;
            if (stall_max > 0) begin
                int stall;
                stall = $urandom_range(0, stall_max);
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                got  = m_tvalid;
                data = m_tdata;
                @(posedge aclk);
            end while (!got);
            route_table.check_verdict(data);
            results_seen++;
        end
    end

    // Watchdog: end the run if neither side moves a transaction for too long.
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule

// ===== longest_prefix_match_router.f =====
rtl/lpmr_pkg.sv
rtl/lpmr_cell.sv
rtl/longest_prefix_match_router.sv
bench/longest_prefix_match_router_tb.sv
